[src/crt_pkg.sv]
// crt_pkg: shared constants, codes and types of the cpu reservation table
// no dependencies; compile first

package crt_pkg;

  localparam int CPU_SLOTS  = 8;
  localparam int SLOT_W     = $clog2(CPU_SLOTS);
  localparam int SLOT_OUT_W = 6;
  localparam int PID_W      = 17;
  localparam int PRIO_W     = 8;
  localparam int CLS_W      = 3;
  localparam int CNT_W      = 16;
  localparam int NUM_CLS    = 4;

  localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CPU_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  // need classes
  localparam logic [CLS_W-1:0] CLS_LOWPERF  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_STANDARD = 3'd1;
  localparam logic [CLS_W-1:0] CLS_HIGHPERF = 3'd2;
  localparam logic [CLS_W-1:0] CLS_CRITICAL = 3'd3;

  // item modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } crt_state_t;

  typedef struct packed {
    logic             mode;
    logic             is_idle;
    logic             has_metadata;
    logic             wants_cpu;
    logic [CLS_W-1:0] need_class;
    logic [PID_W-1:0] proc_id;
    logic [PRIO_W-1:0] priority_req;
  } crt_item_t;

  typedef struct packed {
    logic                  granted;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  displaced;
    logic [PID_W-1:0]      displaced_pid;
    logic [CNT_W-1:0]      lowperf_count;
    logic [CNT_W-1:0]      standard_count;
    logic [CNT_W-1:0]      highperf_count;
    logic [CNT_W-1:0]      critical_count;
  } crt_result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } crt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic out_free;
  } crt_sts_t;

endpackage

[src/crt_if.sv]
// crt_in_if / crt_out_if: valid/ready channels of the cpu reservation table
// depends on crt_pkg for field widths

interface crt_in_if;
  import crt_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic              is_idle;
  logic              has_metadata;
  logic              wants_cpu;
  logic [CLS_W-1:0]  need_class;
  logic [PID_W-1:0]  proc_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (
    output valid, mode, is_idle, has_metadata, wants_cpu, need_class, proc_id,
           priority_req,
    input  ready
  );

  modport sink (
    input  valid, mode, is_idle, has_metadata, wants_cpu, need_class, proc_id,
           priority_req,
    output ready
  );
endinterface

interface crt_out_if;
  import crt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  displaced;
  logic [PID_W-1:0]      displaced_pid;
  logic [CNT_W-1:0]      lowperf_count;
  logic [CNT_W-1:0]      standard_count;
  logic [CNT_W-1:0]      highperf_count;
  logic [CNT_W-1:0]      critical_count;

  modport source (
    output valid, granted, slot_index, displaced, displaced_pid, lowperf_count,
           standard_count, highperf_count, critical_count,
    input  ready
  );

  modport sink (
    input  valid, granted, slot_index, displaced, displaced_pid, lowperf_count,
           standard_count, highperf_count, critical_count,
    output ready
  );
endinterface

[src/crt_ctrl.sv]
// crt_ctrl: sequencer of the reservation table (accept, slot scan, commit)
// depends on crt_pkg

module crt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crt_pkg::crt_sts_t sts,
  output crt_pkg::crt_cmd_t cmd
);
  import crt_pkg::*;

  crt_state_t state_r;
  crt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.needs_scan) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_done) state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/crt_dp.sv]
// crt_dp: slot table, class counters, slot scan and output register
// depends on crt_pkg

module crt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crt_pkg::crt_item_t   in_item,
  input  crt_pkg::crt_cmd_t    cmd,
  output crt_pkg::crt_sts_t    sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crt_pkg::crt_result_t out_res
);
  import crt_pkg::*;

  crt_item_t item_r;

  logic [CPU_SLOTS-1:0] reserved_r;
  logic [PID_W-1:0]     owner_r [CPU_SLOTS];
  logic [PRIO_W-1:0]    prio_r  [CPU_SLOTS];
  logic [CNT_W-1:0]     cnt_r   [NUM_CLS];
  logic [CNT_W-1:0]     cnt_nxt [NUM_CLS];

  logic [SLOT_W-1:0] scan_idx_r;
  logic [SLOT_W-1:0] pick_r;
  logic [PRIO_W-1:0] worst_r;
  logic              found_r;

  logic              out_valid_r;
  crt_result_t       res_r;

  logic              req;
  logic              grant;
  logic              slot_free;
  logic              evict;
  logic              bump_en;

  assign req = (item_r.mode == MODE_RECORD) && !item_r.is_idle &&
               item_r.has_metadata && item_r.wants_cpu;
  assign grant     = req && (found_r || (item_r.priority_req < worst_r));
  assign evict     = grant && reserved_r[pick_r];
  assign slot_free = !reserved_r[scan_idx_r];

  assign sts.needs_scan = req;
  assign sts.scan_done  = slot_free || (scan_idx_r == LAST_SLOT);
  assign sts.out_free   = !out_valid_r || out_ready;

  // class counters after this item
  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (item_r.has_metadata) begin
        bump_en = (item_r.need_class == CLS_W'(k));
      end else begin
        bump_en = (CLS_W'(k) == CLS_STANDARD);
      end
      if (item_r.mode == MODE_CLEAR) begin
        cnt_nxt[k] = '0;
      end else if (!item_r.is_idle && bump_en && (cnt_r[k] != CNT_MAX)) begin
        cnt_nxt[k] = cnt_r[k] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_item;
      scan_idx_r <= FIRST_SLOT;
      pick_r     <= FIRST_SLOT;
      worst_r    <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
      if (slot_free) begin
        pick_r  <= scan_idx_r;
        found_r <= 1'b1;
      end else if ((scan_idx_r == FIRST_SLOT) || (prio_r[scan_idx_r] > worst_r)) begin
        pick_r  <= scan_idx_r;
        worst_r <= prio_r[scan_idx_r];
      end
    end
  end

  // slot payload, only read where the reserved flag is set
  always_ff @(posedge clk) begin
    if (cmd.commit && grant) begin
      owner_r[pick_r] <= item_r.proc_id;
      prio_r[pick_r]  <= item_r.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= '0;
      for (int k = 0; k < NUM_CLS; k++) cnt_r[k] <= '0;
    end else if (cmd.commit) begin
      if (item_r.mode == MODE_CLEAR) begin
        reserved_r <= '0;
      end else if (grant) begin
        reserved_r[pick_r] <= 1'b1;
      end
      for (int k = 0; k < NUM_CLS; k++) cnt_r[k] <= cnt_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r.granted        <= grant;
      res_r.slot_index     <= grant ? SLOT_OUT_W'(pick_r) : '0;
      res_r.displaced      <= evict;
      res_r.displaced_pid  <= evict ? owner_r[pick_r] : '0;
      res_r.lowperf_count  <= cnt_nxt[CLS_LOWPERF[1:0]];
      res_r.standard_count <= cnt_nxt[CLS_STANDARD[1:0]];
      res_r.highperf_count <= cnt_nxt[CLS_HIGHPERF[1:0]];
      res_r.critical_count <= cnt_nxt[CLS_CRITICAL[1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

[src/cpu_reservation_table_top.sv]
// cpu_reservation_table_top: cpu slot reservation table with class counters
// depends on crt_pkg, crt_if, crt_ctrl and crt_dp
//
//   channel  dir  handshake             payload
//   in_ch    in   in_ch.valid/ready     mode, is_idle, has_metadata, wants_cpu,
//                                       need_class, proc_id, priority_req
//   out_ch   out  out_ch.valid/ready    granted, slot_index, displaced,
//                                       displaced_pid, four class counts
//
// one transaction at a time: accept, scan, commit. a clear, idle, plain or
// non-requesting record skips the scan; a slot request examines slots 1 to
// CPU_SLOTS-1 with the one-slot-a-cycle compare and stops at the first free slot.
// reset releases every slot at once through the reserved flags; no sweep.
// the result sits in an output register, so a stalled out_ch only holds the
// commit of the following transaction, not its acceptance and scan.

module cpu_reservation_table_top (
  input  logic clk,
  input  logic rst_n,
  crt_in_if.sink    in_ch,
  crt_out_if.source out_ch
);
  import crt_pkg::*;

  crt_cmd_t    cmd;
  crt_sts_t    sts;
  crt_item_t   item;
  crt_result_t res;
  logic        in_ready;
  logic        out_valid;

  assign item.mode         = in_ch.mode;
  assign item.is_idle      = in_ch.is_idle;
  assign item.has_metadata = in_ch.has_metadata;
  assign item.wants_cpu    = in_ch.wants_cpu;
  assign item.need_class   = in_ch.need_class;
  assign item.proc_id      = in_ch.proc_id;
  assign item.priority_req = in_ch.priority_req;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.granted        = res.granted;
  assign out_ch.slot_index     = res.slot_index;
  assign out_ch.displaced      = res.displaced;
  assign out_ch.displaced_pid  = res.displaced_pid;
  assign out_ch.lowperf_count  = res.lowperf_count;
  assign out_ch.standard_count = res.standard_count;
  assign out_ch.highperf_count = res.highperf_count;
  assign out_ch.critical_count = res.critical_count;

endmodule

[tb/sv/cpu_reservation_table_top_tb.sv]
`timescale 1ns / 100ps
// cpu_reservation_table_top_tb: self-checking bench for the cpu reservation table
// depends on crt_pkg, crt_in_if / crt_out_if and cpu_reservation_table_top

module cpu_reservation_table_top_tb;
  import crt_pkg::*;

  localparam int          RAND_ITEMS   = 1430;
  localparam int          CHUNK        = 50;
  localparam int          MAX_GAP      = 12;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          QUIET_LIMIT  = 1000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          MAX_REPORTS  = 40;
  localparam int          PID_MAX      = 99999;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN_LO = 3'd4;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN_HI = 3'd7;

  typedef struct {
    crt_item_t   item;
    bit          typed;
    crt_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  crt_in_if  in_ch();
  crt_out_if out_ch();

  cpu_reservation_table_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // own copy of the table
  logic              slot_held [CPU_SLOTS];
  logic [PID_W-1:0]  slot_pid  [CPU_SLOTS];
  logic [PRIO_W-1:0] slot_prio [CPU_SLOTS];
  logic [CNT_W-1:0]  class_cnt [NUM_CLS];

  crt_result_t pending_results[$];
  int          mismatches = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int          hold_off_cycles = 0;

  function automatic void bump_class_count(input logic [CLS_W-1:0] cls);
    if (cls < NUM_CLS && class_cnt[cls[1:0]] != CNT_MAX)
      class_cnt[cls[1:0]] = class_cnt[cls[1:0]] + 1'b1;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < CPU_SLOTS; i++) begin
      slot_held[i] = 1'b0;
      slot_pid[i]  = '0;
      slot_prio[i] = '1;
    end
    for (int i = 0; i < NUM_CLS; i++)
      class_cnt[i] = '0;
  endfunction

  // applies one record to the table copy and returns what the block should report
  function automatic crt_result_t apply_to_table(input crt_item_t it);
    crt_result_t       r;
    int                pick;
    logic [PRIO_W-1:0] worst;
    bit                found;
    r = '0;
    if (it.mode == MODE_CLEAR) begin
      wipe_table();
    end else if (!it.is_idle) begin
      if (!it.has_metadata) begin
        bump_class_count(CLS_STANDARD);
      end else begin
        if (it.wants_cpu) begin
          pick  = 1;
          worst = '0;
          found = 1'b0;
          // first free slot wins; otherwise the largest priority number, lowest slot on a tie
          for (int i = 1; i < CPU_SLOTS && !found; i++) begin
            if (!slot_held[i]) begin
              pick  = i;
              found = 1'b1;
            end else if (i == 1 || slot_prio[i] > worst) begin
              pick  = i;
              worst = slot_prio[i];
            end
          end
          if (found || it.priority_req < worst) begin
            if (slot_held[pick]) begin
              r.displaced     = 1'b1;
              r.displaced_pid = slot_pid[pick];
            end
            slot_held[pick] = 1'b1;
            slot_pid[pick]  = it.proc_id;
            slot_prio[pick] = it.priority_req;
            r.granted       = 1'b1;
            r.slot_index    = SLOT_OUT_W'(pick);
          end
        end
        bump_class_count(it.need_class);
      end
    end
    r.lowperf_count  = class_cnt[CLS_LOWPERF[1:0]];
    r.standard_count = class_cnt[CLS_STANDARD[1:0]];
    r.highperf_count = class_cnt[CLS_HIGHPERF[1:0]];
    r.critical_count = class_cnt[CLS_CRITICAL[1:0]];
    return r;
  endfunction

  function automatic crt_item_t mk_item(input logic mode, input int idle, input int meta,
                                        input int wants, input logic [CLS_W-1:0] cls,
                                        input int pid, input int prio);
    crt_item_t it;
    it.mode         = mode;
    it.is_idle      = idle[0];
    it.has_metadata = meta[0];
    it.wants_cpu    = wants[0];
    it.need_class   = cls;
    it.proc_id      = PID_W'(pid);
    it.priority_req = PRIO_W'(prio);
    return it;
  endfunction

  function automatic crt_result_t mk_res(input int grant, input int slot, input int disp,
                                         input int dpid, input int lo, input int st,
                                         input int hi, input int cr);
    crt_result_t r;
    r.granted        = grant[0];
    r.slot_index     = SLOT_OUT_W'(slot);
    r.displaced      = disp[0];
    r.displaced_pid  = PID_W'(dpid);
    r.lowperf_count  = CNT_W'(lo);
    r.standard_count = CNT_W'(st);
    r.highperf_count = CNT_W'(hi);
    r.critical_count = CNT_W'(cr);
    return r;
  endfunction

  function automatic crt_item_t random_item();
    crt_item_t it;
    int        roll;
    roll            = $urandom_range(0, 99);
    it.mode         = (roll < 3) ? MODE_CLEAR : MODE_RECORD;
    it.is_idle      = (roll >= 3 && roll < 8);
    it.has_metadata = (roll >= 18);
    it.wants_cpu    = ($urandom_range(0, 99) < 70);
    // mostly known classes, now and then an unrecognised one
    if ($urandom_range(0, 9) == 0)
      it.need_class = CLS_W'($urandom_range(CLS_UNKNOWN_LO, CLS_UNKNOWN_HI));
    else
      it.need_class = CLS_W'($urandom_range(CLS_LOWPERF, CLS_CRITICAL));
    it.proc_id      = PID_W'($urandom_range(0, PID_MAX));
    it.priority_req = PRIO_W'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_item(input crt_item_t it, input int gap, input bit typed,
                           input crt_result_t typed_res);
    crt_result_t pred;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode         <= it.mode;
    in_ch.is_idle      <= it.is_idle;
    in_ch.has_metadata <= it.has_metadata;
    in_ch.wants_cpu    <= it.wants_cpu;
    in_ch.need_class   <= it.need_class;
    in_ch.proc_id      <= it.proc_id;
    in_ch.priority_req <= it.priority_req;
    in_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = apply_to_table(it);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result side: random stalls, one long hold-off on request, checks every transaction
  initial begin : result_sink
    int          stall;
    crt_result_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding, expected none actual slot %0d",
                   $time, out_ch.slot_index);
      end else begin
        want = pending_results.pop_front();
        check_field("granted",        64'(want.granted),        64'(out_ch.granted));
        check_field("slot_index",     64'(want.slot_index),     64'(out_ch.slot_index));
        check_field("displaced",      64'(want.displaced),      64'(out_ch.displaced));
        check_field("displaced_pid",  64'(want.displaced_pid),  64'(out_ch.displaced_pid));
        check_field("lowperf_count",  64'(want.lowperf_count),  64'(out_ch.lowperf_count));
        check_field("standard_count", 64'(want.standard_count), 64'(out_ch.standard_count));
        check_field("highperf_count", 64'(want.highperf_count), 64'(out_ch.highperf_count));
        check_field("critical_count", 64'(want.critical_count), 64'(out_ch.critical_count));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    dir_rows[$];
    crt_result_t no_res;
    no_res             = '0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_RECORD;
    in_ch.is_idle      = 1'b0;
    in_ch.has_metadata = 1'b0;
    in_ch.wants_cpu    = 1'b0;
    in_ch.need_class   = CLS_LOWPERF;
    in_ch.proc_id      = '0;
    in_ch.priority_req = '0;
    wipe_table();

    // clear with every other field set, idle, plain, then fill the table
    dir_rows.push_back('{mk_item(MODE_CLEAR, 1, 1, 1, CLS_UNKNOWN_HI, PID_MAX, 255), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 1, 1, 1, CLS_CRITICAL, 5, 0), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 0, 1, CLS_CRITICAL, 6, 0), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 1, 0, 0)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_CRITICAL, PID_MAX, 0), 1'b1,
                         mk_res(1, 1, 0, 0, 0, 1, 0, 1)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 0, CLS_LOWPERF, 0, 255), 1'b1,
                         mk_res(0, 0, 0, 0, 1, 1, 0, 1)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_HIGHPERF, 0, 255), 1'b1,
                         mk_res(1, 2, 0, 0, 1, 1, 1, 1)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_STANDARD, 11, 10), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_STANDARD, 12, 200), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_STANDARD, 13, 50), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_STANDARD, 14, 254), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_STANDARD, 15, 30), 1'b0, no_res});
    // table full: equal priority is refused, then displacements incl. a tie
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_UNKNOWN_LO, 20, 255), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_UNKNOWN_HI, 21, 254), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_LOWPERF, 22, 0), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_HIGHPERF, 23, 0), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 1, 1, 1, CLS_CRITICAL, 24, 0), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, CLS_CRITICAL, 25, 255), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_CLEAR, 0, 0, 0, CLS_LOWPERF, 0, 0), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 1, 1, 3'd5, PID_MAX, 255), 1'b0, no_res});
    dir_rows.push_back('{mk_item(MODE_RECORD, 0, 0, 0, CLS_UNKNOWN_HI, 77, 128), 1'b0, no_res});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (dir_rows[k])
      send_item(dir_rows[k].item, $urandom_range(0, MAX_GAP), dir_rows[k].typed,
                dir_rows[k].res);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % CHUNK == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        if (n / CHUNK == 1) begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        // long receiver hold-off while transactions keep coming
        if (n / CHUNK == 3) begin
          tx_idle_on      = 1'b0;
          hold_off_cycles = HOLD_CYCLES;
        end
      end
      send_item(random_item(), tx_idle_on ? $urandom_range(0, MAX_GAP) : 0, 1'b0, no_res);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results still outstanding, expected 0", $time,
               pending_results.size());
    end
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
